// ===== rtl/eer_pkg.sv =====
package eer_pkg;

   localparam int NUM_ERRORS_DEFAULT = 8;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_COMM_FIRST  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMM_SECOND = 1'd1;

   localparam logic [2:0] COMM_FIRST_RESET  = 3'd0;
   localparam logic [2:0] COMM_SECOND_RESET = 3'd1;

   typedef enum logic [1:0] {
      CMD_ACTIVATE   = 2'd0,
      CMD_DEACTIVATE = 2'd1,
      CMD_RAISE      = 2'd2,
      CMD_POLL       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_FIRED   = 2'd0,
      KIND_RAISED  = 2'd1,
      KIND_CLEARED = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      LED_UNCHANGED = 2'd0,
      LED_BLINK     = 2'd1,
      LED_OFF       = 2'd2
   } led_type;

   typedef struct packed {
      cmd_type    command;
      logic [2:0] error_number;
      logic       unsolicited;
   } req_word_type;

   typedef struct packed {
      logic       report_valid;
      logic [2:0] report_error;
      kind_type   report_kind;
      led_type    led_action;
      logic [3:0] blink_count;
      logic       blink_repeat;
      logic [7:0] active_mask;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0] comm_first;
      logic [2:0] comm_second;
   } comm_cfg_type;

endpackage

// ===== rtl/eer_if.sv =====
interface eer_req_if;
   logic                 valid;
   logic                 ready;
   eer_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface eer_rsp_if;
   logic                 valid;
   logic                 ready;
   eer_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/eer_csr.sv =====
module eer_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [eer_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [eer_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output eer_pkg::comm_cfg_type            cfg
);
   import eer_pkg::*;

   logic [2:0] first_ff, first_in;
   logic [2:0] second_ff, second_in;

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COMM_FIRST:  first_in  = csr_write_data;
            CSR_COMM_SECOND: second_in = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= COMM_FIRST_RESET;
         second_ff <= COMM_SECOND_RESET;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign cfg.comm_first  = first_ff;
   assign cfg.comm_second = second_ff;

endmodule

// ===== rtl/eer_engine.sv =====
module eer_engine #(
   parameter int NUM_ERRORS = eer_pkg::NUM_ERRORS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  eer_pkg::req_word_type word,
   input  eer_pkg::comm_cfg_type cfg,
   output eer_pkg::rsp_word_type result
);
   import eer_pkg::*;

   localparam int IDX_W = (NUM_ERRORS > 1) ? $clog2(NUM_ERRORS) : 1;

   typedef logic [NUM_ERRORS-1:0] mask_type;

   mask_type active_ff, active_in;
   mask_type fired_ff, fired_in;
   mask_type raised_ff, raised_in;
   mask_type cleared_ff, cleared_in;

   logic             in_range;
   mask_type         sel;
   mask_type         any_pending;
   logic [IDX_W-1:0] poll_idx;
   mask_type         poll_bit;
   logic             suppressed;
   mask_type         remain;
   logic [IDX_W-1:0] remain_idx;

   function automatic logic [IDX_W-1:0] lowest_index(input mask_type vec);
      mask_type         low;
      logic [IDX_W-1:0] idx;
      low = vec & (~vec + mask_type'(1));
      idx = '0;
      for (int i = 0; i < NUM_ERRORS; i++) begin
         if (low[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
      return idx;
   endfunction

   assign in_range    = int'(word.error_number) < NUM_ERRORS;
   assign sel         = in_range ? (mask_type'(1) << word.error_number) : '0;
   assign any_pending = fired_ff | raised_ff | cleared_ff;
   assign poll_idx    = lowest_index(any_pending);
   assign poll_bit    = mask_type'(1) << poll_idx;
   assign suppressed  = word.unsolicited &&
                        ((32'(poll_idx) == 32'(cfg.comm_first)) ||
                         (32'(poll_idx) == 32'(cfg.comm_second)));
   assign remain      = active_ff & ~sel;
   assign remain_idx  = lowest_index(remain);

   always_comb begin
      active_in  = active_ff;
      fired_in   = fired_ff;
      raised_in  = raised_ff;
      cleared_in = cleared_ff;
      result     = '0;

      unique case (word.command)
         CMD_POLL: begin
            if (|any_pending) begin
               priority if (|(fired_ff & poll_bit)) begin
                  fired_in           = fired_ff & ~poll_bit;
                  result.report_kind = KIND_FIRED;
               end else if (|(raised_ff & poll_bit)) begin
                  raised_in          = raised_ff & ~poll_bit;
                  result.report_kind = KIND_RAISED;
               end else begin
                  cleared_in         = cleared_ff & ~poll_bit;
                  result.report_kind = KIND_CLEARED;
               end
               if (suppressed) begin
                  result.report_kind = KIND_FIRED;
               end else begin
                  result.report_valid = 1'b1;
                  result.report_error = 3'(poll_idx);
               end
            end
         end
         CMD_ACTIVATE: begin
            if (in_range && !(|(active_ff & sel))) begin
               active_in           = active_ff | sel;
               raised_in           = raised_ff | sel;
               result.led_action   = LED_BLINK;
               result.blink_count  = 4'(int'(word.error_number) + 1);
               result.blink_repeat = 1'b1;
            end
         end
         CMD_DEACTIVATE: begin
            if (in_range && |(active_ff & sel)) begin
               active_in  = remain;
               cleared_in = cleared_ff | sel;
               if (|remain) begin
                  result.led_action   = LED_BLINK;
                  result.blink_count  = 4'(int'(remain_idx) + 1);
                  result.blink_repeat = 1'b1;
               end else begin
                  result.led_action = LED_OFF;
               end
            end
         end
         CMD_RAISE: begin
            if (in_range && (active_ff == '0)) begin
               fired_in           = fired_ff | sel;
               result.led_action  = LED_BLINK;
               result.blink_count = 4'(int'(word.error_number) + 1);
            end
         end
      endcase

      result.active_mask = 8'(active_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         fired_ff   <= '0;
         raised_ff  <= '0;
         cleared_ff <= '0;
      end else if (fire) begin
         active_ff  <= active_in;
         fired_ff   <= fired_in;
         raised_ff  <= raised_in;
         cleared_ff <= cleared_in;
      end
   end

   // A report can only come from a poll.
   assert property (@(posedge clock) disable iff (reset)
      result.report_valid |-> (word.command == CMD_POLL))
      else $error("report without a poll");

   // A blinking LED always carries a nonzero count.
   assert property (@(posedge clock) disable iff (reset)
      (result.led_action == LED_BLINK) |-> (result.blink_count != 4'd0))
      else $error("blink with zero count");

   // An accepted activate leaves the addressed error active.
   assert property (@(posedge clock) disable iff (reset)
      (fire && (word.command == CMD_ACTIVATE) && in_range)
      |=> |(active_ff & $past(sel)))
      else $error("activate did not set the active bit");

   // A poll with anything pending retires exactly one pending bit.
   assert property (@(posedge clock) disable iff (reset)
      (fire && (word.command == CMD_POLL) && |any_pending)
      |=> ($countones({fired_ff, raised_ff, cleared_ff}) + 1 ==
           $past($countones({fired_ff, raised_ff, cleared_ff}))))
      else $error("poll did not retire exactly one pending event");

endmodule

// ===== rtl/error_event_reporter_core.sv =====
// A command word accepted into the input register is evaluated by the engine, and
// its response word is captured in the response register, which drives the bus.
// Throughput: one command word per cycle unless the response bus stalls; the
// pending-event priority encoder between the two registers is combinational.
// Reset is synchronous and clears all active and pending error masks.
module error_event_reporter_core #(
   parameter int NUM_ERRORS = eer_pkg::NUM_ERRORS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   eer_req_if.sink                         req_bus,
   eer_rsp_if.source                       rsp_bus,
   input  logic                            csr_write_enable,
   input  logic [eer_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [eer_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import eer_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;

   logic         advance;
   logic         accept;
   comm_cfg_type cfg;
   rsp_word_type result;

   eer_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   eer_engine #(
      .NUM_ERRORS (NUM_ERRORS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .word   (in_word_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_word_in  = result;
      end else if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_word_in  = req_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         in_word_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         in_word_ff   <= in_word_in;
      end
      out_word_ff <= out_word_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_word_ff;

endmodule
